// ===== rtl/core/rk4_pkg.sv =====
// shared types, constants and saturating helpers for the rk4 ode stepper
// no dependencies; imported by rk4_mulu and rk4_ode_stepper_core
package rk4_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int FRACTION_BITS  = 16;
   localparam int PROD_WIDTH     = 2 * DATA_WIDTH;
   localparam int DIV_DIGIT      = 8;
   localparam int DIV_STEPS      = PROD_WIDTH / DIV_DIGIT;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam int DIVISOR        = 6;
   localparam int REM_WIDTH      = 3;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [DATA_WIDTH-1:0] STEP_SIZE_RESET = DATA_WIDTH'(6554);
   localparam logic [DATA_WIDTH-1:0] END_X_RESET     = DATA_WIDTH'(65536);
   localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_STEP_SIZE = 1'b0,
      REG_END_X     = 1'b1
   } csr_reg_type;

   typedef struct packed {
      cmd_type  command;
      word_type start_x;
      word_type start_y;
   } req_type;

   typedef struct packed {
      word_type x_value;
      word_type y_value;
      logic     reached_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K1,
      ST_MUL,
      ST_SCALE,
      ST_KN,
      ST_SUM,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STG_K1,
      STG_K2,
      STG_K3,
      STG_SUM
   } stage_type;

   typedef struct packed {
      logic mul_en;
      logic div_en;
   } mulu_ctl_type;

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [DATA_WIDTH:0] s;
      word_type            r;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         r = s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end else begin
         r = s[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic word_type half(input word_type v);
      return v >>> 1;
   endfunction

endpackage

// ===== rtl/core/rk4_mulu.sv =====
// shared multiplier: |a|*|b| product register, divide-by-six digit unit
// and rounding/saturating rescale; depends on rk4_pkg
module rk4_mulu import rk4_pkg::*; (
   input  logic         clock,
   input  mulu_ctl_type ctl,
   input  word_type     op_a,
   input  word_type     op_b,
   output word_type     result
);

   localparam int SH_WIDTH = PROD_WIDTH + 1 - FRACTION_BITS;

   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;

   logic [DATA_WIDTH-1:0] mag_a, mag_b;
   logic [DIV_DIGIT-1:0]  quo;
   logic [REM_WIDTH:0]    cur;
   logic [REM_WIDTH-1:0]  rem;

   logic [PROD_WIDTH:0]   rnd_sum;
   logic [SH_WIDTH-1:0]   shifted, limit;
   logic [DATA_WIDTH-1:0] mag;

   always_comb begin
      mag_a = op_a[DATA_WIDTH-1] ? -op_a : op_a;
      mag_b = op_b[DATA_WIDTH-1] ? -op_b : op_b;

      rem = rem_ff;
      quo = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         cur = {rem, prod_ff[PROD_WIDTH-1-i]};
         quo[DIV_DIGIT-1-i] = (cur >= (REM_WIDTH+1)'(DIVISOR));
         rem = quo[DIV_DIGIT-1-i] ? REM_WIDTH'(cur - (REM_WIDTH+1)'(DIVISOR))
                                  : REM_WIDTH'(cur);
      end

      prod_in = prod_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      if (ctl.mul_en) begin
         prod_in = PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
         neg_in  = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
         rem_in  = '0;
      end else if (ctl.div_en) begin
         prod_in = {prod_ff[PROD_WIDTH-DIV_DIGIT-1:0], quo};
         rem_in  = rem;
      end
   end

   always_comb begin
      rnd_sum = {1'b0, prod_ff} + ((PROD_WIDTH+1)'(1) << (FRACTION_BITS - 1));
      shifted = rnd_sum[PROD_WIDTH:FRACTION_BITS];
      limit   = neg_ff ? (SH_WIDTH'(1) << (DATA_WIDTH - 1))
                       : ((SH_WIDTH'(1) << (DATA_WIDTH - 1)) - SH_WIDTH'(1));
      mag     = (shifted > limit) ? DATA_WIDTH'(limit) : DATA_WIDTH'(shifted);
      result  = neg_ff ? word_type'(-mag) : word_type'(mag);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
   end

endmodule

// ===== rtl/core/rk4_ode_stepper_core.sv =====
// rk4 ode stepper for dy/dx = x + y in signed q16.16 with apb-style csr port
// a load or a step after end goes straight to done; a step runs k1, then mul, scale and
// kn per stage, sum, mul, div, scale and fin; words are accepted only in idle; the shared
// multiplier runs four products and the divide-by-six unit takes 8 bits per digit step
// synchronous active-high reset: point and end flag cleared, csr to 6554 / 65536
// depends on rk4_pkg and rk4_mulu
module rk4_ode_stepper_core import rk4_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   state_type                state_ff, state_in;
   stage_type                stg_ff, stg_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   word_type                 step_size_ff, step_size_in;
   word_type                 end_x_ff, end_x_in;
   word_type                 point_x_ff, point_x_in;
   word_type                 point_y_ff, point_y_in;
   logic                     finished_ff, finished_in;
   word_type                 xm_ff, xm_in;
   word_type                 xe_ff, xe_in;
   word_type                 acc_a_ff, acc_a_in;
   word_type                 acc_b_ff, acc_b_in;
   word_type                 kcur_ff, kcur_in;
   word_type                 p_ff, p_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   mulu_ctl_type             mulu_ctl;
   word_type                 mulu_result;
   logic                     req_fire, out_free, csr_write;
   csr_reg_type              csr_sel;
   word_type                 kn_base, kn_add;

   rk4_mulu u_mulu (
      .clock  (clock),
      .ctl    (mulu_ctl),
      .op_a   (step_size_ff),
      .op_b   (kcur_ff),
      .result (mulu_result)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_WIDTH-1]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_sel == REG_END_X) ? end_x_ff : step_size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_LOAD || finished_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_K1;
               end
            end
         end
         ST_K1:    state_in = ST_MUL;
         ST_MUL:   state_in = (stg_ff == STG_SUM) ? ST_DIV : ST_SCALE;
         ST_SCALE: state_in = (stg_ff == STG_SUM) ? ST_FIN : ST_KN;
         ST_KN:    state_in = (stg_ff == STG_K3) ? ST_SUM : ST_MUL;
         ST_SUM:   state_in = ST_MUL;
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_FIN:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      stg_in       = stg_ff;
      div_cnt_in   = div_cnt_ff;
      step_size_in = step_size_ff;
      end_x_in     = end_x_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      finished_in  = finished_ff;
      xm_in        = xm_ff;
      xe_in        = xe_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      kcur_in      = kcur_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mulu_ctl     = '0;
      kn_base      = (stg_ff == STG_K3) ? xe_ff : xm_ff;
      kn_add       = (stg_ff == STG_K3) ? p_ff : half(p_ff);

      if (csr_write) begin
         if (csr_sel == REG_END_X) begin
            end_x_in = csr_pwdata;
         end else begin
            step_size_in = csr_pwdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.command == CMD_LOAD) begin
               point_x_in  = req_data.start_x;
               point_y_in  = req_data.start_y;
               finished_in = 1'b0;
            end
         end
         ST_K1: begin
            kcur_in  = sat_add(point_x_ff, point_y_ff);
            acc_a_in = sat_add(point_x_ff, point_y_ff);
            xm_in    = sat_add(point_x_ff, half(step_size_ff));
            xe_in    = sat_add(point_x_ff, step_size_ff);
            stg_in   = STG_K1;
         end
         ST_MUL: begin
            mulu_ctl.mul_en = 1'b1;
            div_cnt_in      = '0;
            if (stg_ff == STG_K2) begin
               acc_a_in = sat_add(acc_a_ff, sat_add(kcur_ff, kcur_ff));
            end
            if (stg_ff == STG_K3) begin
               acc_b_in = sat_add(kcur_ff, kcur_ff);
            end
         end
         ST_SCALE: begin
            p_in = mulu_result;
         end
         ST_KN: begin
            kcur_in = sat_add(kn_base, sat_add(point_y_ff, kn_add));
            if (stg_ff != STG_K3) begin
               stg_in = stage_type'(stg_ff + 2'd1);
            end
         end
         ST_SUM: begin
            kcur_in = sat_add(acc_a_ff, sat_add(acc_b_ff, kcur_ff));
            stg_in  = STG_SUM;
         end
         ST_DIV: begin
            mulu_ctl.div_en = 1'b1;
            div_cnt_in      = div_cnt_ff + DIV_CNT_WIDTH'(1);
         end
         ST_FIN: begin
            point_y_in  = sat_add(point_y_ff, p_ff);
            point_x_in  = xe_ff;
            finished_in = (step_size_ff < 0 && xe_ff <= end_x_ff) ||
                          (step_size_ff > 0 && xe_ff >= end_x_ff);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.x_value     = point_x_ff;
               rsp_in.y_value     = point_y_ff;
               rsp_in.reached_end = finished_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stg_ff       <= STG_K1;
         div_cnt_ff   <= '0;
         step_size_ff <= STEP_SIZE_RESET;
         end_x_ff     <= END_X_RESET;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stg_ff       <= stg_in;
         div_cnt_ff   <= div_cnt_in;
         step_size_ff <= step_size_in;
         end_x_ff     <= end_x_in;
         point_x_ff   <= point_x_in;
         point_y_ff   <= point_y_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xm_ff    <= xm_in;
      xe_ff    <= xe_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      kcur_ff  <= kcur_in;
      p_ff     <= p_in;
      rsp_ff   <= rsp_in;
   end

   a_end_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(finished_ff) |-> $past(state_ff) == ST_FIN)
      else $error("end flag set outside the final step state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_DIV || state_ff == ST_SCALE)
      else $error("divider left early");

   a_sum_to_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> state_ff == ST_MUL && stg_ff == STG_SUM)
      else $error("weighted sum not sent to the multiplier");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

endmodule
